### sv/rlpk_pkg.sv
// Shared widths, constants and bundle types for the relative Lorentz pair kernel.
package rlpk_pkg;

    // Input number formats.
    localparam int POS_FRAC_BITS = 16;
    localparam int VEL_FRAC_BITS = 17;
    localparam int POS_W = POS_FRAC_BITS;
    localparam int VEL_W = VEL_FRAC_BITS + 1;

    // Intermediate widths of the front end.
    localparam int DX_W   = POS_W + 1;              // signed position difference
    localparam int SQ_W   = 2 * VEL_FRAC_BITS + 1;  // one velocity component squared
    localparam int S_W    = SQ_W + 1;               // squared speed, up to 3 * one
    localparam int D_W    = 2 * VEL_FRAC_BITS + 1;  // one - squared speed
    localparam int DOT_W  = 2 * VEL_W;              // one product of v1 and v2
    localparam int DOTS_W = DOT_W + 1;              // v1 dot v2
    localparam int W_W    = DOTS_W;                 // one - v1 dot v2, clamped
    localparam int VDXP_W = VEL_W + DX_W;           // one product of v1 and dx
    localparam int VDXS_W = VDXP_W + 1;             // v1 dot dx
    localparam int AVDX_W = VDXS_W - 1;             // magnitude of v1 dot dx
    localparam int DD_W   = 2 * POS_W;              // one dx component squared
    localparam int DX2_W  = DD_W + 2;               // squared lab distance

    // Wide multiplier.
    localparam int MUL_W   = 36;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int MUL_LAT = 2;

    // Back-end units.
    localparam int GAM_ROOT_W = 49;
    localparam int GAM_SHIFT  = 28;
    localparam int GAM_QUO_W  = 32;
    localparam int SEP_QUO_W  = 48;
    localparam int SEP_ROOT_W = 24;

    // Output widths and limits.
    localparam int SEP_W = 24;
    localparam int GAM_W = 32;
    localparam logic [SEP_W-1:0] SEP_MAX = '1;
    localparam logic [GAM_W-1:0] GAM_MAX = '1;
    localparam logic [GAM_W-1:0] GAM_MIN = GAM_W'(65536);

    // Separation mode codes.
    localparam logic MODE_LAB    = 1'b0;
    localparam logic MODE_PROPER = 1'b1;

    // Pipeline timing.
    localparam int FRONT_LAT   = 3;
    localparam int GAM_SIDE_DLY = MUL_LAT + GAM_ROOT_W;
    localparam int GAM_LAT     = MUL_LAT + GAM_ROOT_W + 1 + GAM_QUO_W;
    localparam int SEP_LAT     = MUL_LAT + 1 + SEP_QUO_W + 1 + SEP_ROOT_W;
    localparam int SEP_ALIGN   = GAM_LAT - SEP_LAT;
    localparam int PIPE_DEPTH  = FRONT_LAT + GAM_LAT;

    // Side data of the gamma path.
    typedef struct packed {
        logic [W_W-1:0] w;
        logic           bad;
    } gam_side_t;

    typedef struct packed {
        logic sat;
        logic bad;
    } gam_tail_t;

    // Side data of the separation path.
    typedef struct packed {
        logic [D_W-1:0]   d1;
        logic [DX2_W-1:0] dx2;
        logic             bad1;
    } sep_side_t;

    typedef struct packed {
        logic [DX2_W-1:0] dx2;
        logic             bad1;
        logic             sat;
    } sep_mid_t;

    typedef struct packed {
        logic force_zero;
        logic force_max;
    } sep_flags_t;

    // One result beat.
    typedef struct packed {
        logic [SEP_W-1:0] separation;
        logic [GAM_W-1:0] relative_gamma;
        logic             speed_invalid;
    } result_t;

endpackage

### sv/rlpk_delay.sv
// Enabled shift line that keeps side data aligned with a pipelined unit.
module rlpk_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = rlpk_pkg::MUL_LAT
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // Shift one place per advancing cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

### sv/rlpk_mul_wide.sv
// Two-stage unsigned multiplier built from four half-width partial products.
module rlpk_mul_wide #(
    parameter int IN_W = rlpk_pkg::MUL_W
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   a,
    input  logic [IN_W-1:0]   b,
    output logic [2*IN_W-1:0] prod
);

    localparam int LO_W = IN_W / 2;
    localparam int HI_W = IN_W - LO_W;

    logic [2*LO_W-1:0]    ll_next, ll_reg;
    logic [LO_W+HI_W-1:0] lh_next, lh_reg, hl_next, hl_reg;
    logic [2*HI_W-1:0]    hh_next, hh_reg;
    logic [2*IN_W-1:0]    prod_next, prod_reg;

    // First stage: partial products.
    assign ll_next = a[LO_W-1:0] * b[LO_W-1:0];
    assign lh_next = a[LO_W-1:0] * b[IN_W-1:LO_W];
    assign hl_next = a[IN_W-1:LO_W] * b[LO_W-1:0];
    assign hh_next = a[IN_W-1:LO_W] * b[IN_W-1:LO_W];

    // Second stage: weighted sum of the partial products.
    assign prod_next = ((2*IN_W)'(hh_reg) << (2 * LO_W))
                     + (((2*IN_W)'(lh_reg) + (2*IN_W)'(hl_reg)) << LO_W)
                     + (2*IN_W)'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            hh_reg   <= hh_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### sv/rlpk_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rlpk_div #(
    parameter int DEN_W = rlpk_pkg::GAM_ROOT_W,
    parameter int QUO_W = rlpk_pkg::GAM_QUO_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [QUO_W-1:0] num_low,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in, den_in, rem_next;
        logic [QUO_W-1:0] low_in, quo_in, low_next, quo_next;
        logic [DEN_W:0]   trial, diff;
        logic             take;

        if (j == 0)
        begin : g_first
            assign rem_in = rem_init;
            assign den_in = den;
            assign low_in = num_low;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign low_in = low_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // Bring down the next numerator bit and try a subtraction.
        assign trial    = {rem_in, low_in[QUO_W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign take     = trial >= {1'b0, den_in};
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign low_next = {low_in[QUO_W-2:0], 1'b0};
        assign quo_next = {quo_in[QUO_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_in;
                low_reg[j] <= low_next;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

### sv/rlpk_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
module rlpk_sqrt #(
    parameter int ROOT_W = rlpk_pkg::GAM_ROOT_W
) (
    input  logic                clk,
    input  logic                en,
    input  logic [2*ROOT_W-1:0] rad,
    output logic [ROOT_W-1:0]   root
);

    logic [ROOT_W+1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        logic [ROOT_W+1:0]   rem_in, rem_next;
        logic [ROOT_W-1:0]   root_in, root_next;
        logic [2*ROOT_W-1:0] rad_in, rad_next;
        logic [ROOT_W+3:0]   rem2, trial, diff;
        logic                take;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
        end

        // Append the next radicand digit pair and test 4*root+1.
        assign rem2      = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign diff      = rem2 - trial;
        assign take      = rem2 >= trial;
        assign rem_next  = take ? diff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
        assign root_next = {root_in[ROOT_W-2:0], take};
        assign rad_next  = {rad_in[2*ROOT_W-3:0], 2'b00};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= rad_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

### sv/relative_lorentz_pair_kernel_unit.sv
// Throughput: one pair per cycle while in_stall is low; the depth is set by the
// 49-stage gamma square root followed by the 32-stage gamma divider, all of which
// advance together. A stalled output is held in the output register and one skid
// entry; the input stalls only while the skid entry is full.
// Reset (rst_n low, asynchronous) clears all valid bits and selects lab distance.
module relative_lorentz_pair_kernel_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [17:0] first_vel_x,
    input  logic [17:0] first_vel_y,
    input  logic [17:0] first_vel_z,
    input  logic [15:0] first_pos_x,
    input  logic [15:0] first_pos_y,
    input  logic [15:0] first_pos_z,
    input  logic [17:0] second_vel_x,
    input  logic [17:0] second_vel_y,
    input  logic [17:0] second_vel_z,
    input  logic [15:0] second_pos_x,
    input  logic [15:0] second_pos_y,
    input  logic [15:0] second_pos_z,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] separation,
    output logic [31:0] relative_gamma,
    output logic        speed_invalid
);

    localparam int VEL_W  = rlpk_pkg::VEL_W;
    localparam int POS_W  = rlpk_pkg::POS_W;
    localparam int DX_W   = rlpk_pkg::DX_W;
    localparam int SQ_W   = rlpk_pkg::SQ_W;
    localparam int S_W    = rlpk_pkg::S_W;
    localparam int D_W    = rlpk_pkg::D_W;
    localparam int DOT_W  = rlpk_pkg::DOT_W;
    localparam int DOTS_W = rlpk_pkg::DOTS_W;
    localparam int W_W    = rlpk_pkg::W_W;
    localparam int VDXP_W = rlpk_pkg::VDXP_W;
    localparam int VDXS_W = rlpk_pkg::VDXS_W;
    localparam int AVDX_W = rlpk_pkg::AVDX_W;
    localparam int DD_W   = rlpk_pkg::DD_W;
    localparam int DX2_W  = rlpk_pkg::DX2_W;
    localparam int MUL_W  = rlpk_pkg::MUL_W;
    localparam int PROD_W = rlpk_pkg::PROD_W;
    localparam int GRW    = rlpk_pkg::GAM_ROOT_W;
    localparam int GQW    = rlpk_pkg::GAM_QUO_W;
    localparam int SQW    = rlpk_pkg::SEP_QUO_W;
    localparam int SRW    = rlpk_pkg::SEP_ROOT_W;
    localparam int SHIFT  = rlpk_pkg::GAM_SHIFT;
    localparam int DEPTH  = rlpk_pkg::PIPE_DEPTH;

    localparam logic [S_W-1:0]           ONE_S = S_W'(1) << (2 * rlpk_pkg::VEL_FRAC_BITS);
    localparam logic signed [DOTS_W:0]   ONE_W = (DOTS_W+1)'(1) << (2 * rlpk_pkg::VEL_FRAC_BITS);

    // Configuration register.
    logic sep_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_mode_reg <= rlpk_pkg::MODE_LAB;
        end
        else if (cfg_wr_en)
        begin
            sep_mode_reg <= cfg_wr_data;
        end
    end

    // Pipeline advance and valid line.
    logic adv, accept_in, pipe_fire;
    logic valid_reg [DEPTH];
    logic skid_valid_reg, out_valid_reg;

    assign adv       = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign accept_in = in_valid && !skid_valid_reg;
    assign pipe_fire = valid_reg[DEPTH-1] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= accept_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage 1: component differences and products.
    logic signed [VEL_W-1:0] v1 [3];
    logic signed [VEL_W-1:0] v2 [3];
    logic [POS_W-1:0]        p1 [3];
    logic [POS_W-1:0]        p2 [3];

    assign v1[0] = first_vel_x;
    assign v1[1] = first_vel_y;
    assign v1[2] = first_vel_z;
    assign v2[0] = second_vel_x;
    assign v2[1] = second_vel_y;
    assign v2[2] = second_vel_z;
    assign p1[0] = first_pos_x;
    assign p1[1] = first_pos_y;
    assign p1[2] = first_pos_z;
    assign p2[0] = second_pos_x;
    assign p2[1] = second_pos_y;
    assign p2[2] = second_pos_z;

    logic [SQ_W-1:0]          sq1_reg [3];
    logic [SQ_W-1:0]          sq2_reg [3];
    logic signed [DOT_W-1:0]  dot_reg [3];
    logic signed [VDXP_W-1:0] vdx_reg [3];
    logic [DD_W-1:0]          dd_reg  [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic signed [DX_W-1:0]   dx;
        logic signed [DOT_W-1:0]  sq1_full, sq2_full, dot_next;
        logic signed [VDXP_W-1:0] vdx_next;
        logic signed [2*DX_W-1:0] dd_full;

        assign dx       = $signed({1'b0, p2[i]}) - $signed({1'b0, p1[i]});
        assign sq1_full = v1[i] * v1[i];
        assign sq2_full = v2[i] * v2[i];
        assign dot_next = v1[i] * v2[i];
        assign vdx_next = v1[i] * dx;
        assign dd_full  = dx * dx;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq1_reg[i] <= sq1_full[SQ_W-1:0];
                sq2_reg[i] <= sq2_full[SQ_W-1:0];
                dot_reg[i] <= dot_next;
                vdx_reg[i] <= vdx_next;
                dd_reg[i]  <= dd_full[DD_W-1:0];
            end
        end
    end

    // Stage 2: three-term sums.
    logic [S_W-1:0]           s1_next, s2_next, s1_reg, s2_reg;
    logic signed [DOTS_W-1:0] dots_next, dots_reg;
    logic signed [VDXS_W-1:0] vdxs_next, vdxs_reg;
    logic [DX2_W-1:0]         dx2_next, dx2_reg;

    assign s1_next   = S_W'(sq1_reg[0]) + S_W'(sq1_reg[1]) + S_W'(sq1_reg[2]);
    assign s2_next   = S_W'(sq2_reg[0]) + S_W'(sq2_reg[1]) + S_W'(sq2_reg[2]);
    assign dots_next = DOTS_W'(dot_reg[0]) + DOTS_W'(dot_reg[1]) + DOTS_W'(dot_reg[2]);
    assign vdxs_next = VDXS_W'(vdx_reg[0]) + VDXS_W'(vdx_reg[1]) + VDXS_W'(vdx_reg[2]);
    assign dx2_next  = DX2_W'(dd_reg[0]) + DX2_W'(dd_reg[1]) + DX2_W'(dd_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            dots_reg <= dots_next;
            vdxs_reg <= vdxs_next;
            dx2_reg  <= dx2_next;
        end
    end

    // Stage 3: speed checks, distances from light speed and clamped w.
    logic [S_W-1:0]           d1_full, d2_full;
    logic signed [DOTS_W:0]   ws;
    logic signed [VDXS_W-1:0] vdx_neg;
    logic [W_W-1:0]           w_next, w_reg;
    logic [AVDX_W-1:0]        avdx_next, avdx_reg;
    logic [D_W-1:0]           d1_reg, d2_reg;
    logic [DX2_W-1:0]         dx2_s3_reg;
    logic                     bad1_reg, bad2_reg;

    assign d1_full   = ONE_S - s1_reg;
    assign d2_full   = ONE_S - s2_reg;
    assign ws        = ONE_W - (DOTS_W+1)'(dots_reg);
    assign w_next    = (ws[DOTS_W] || ws == '0) ? W_W'(1) : ws[W_W-1:0];
    assign vdx_neg   = -vdxs_reg;
    assign avdx_next = vdxs_reg[VDXS_W-1] ? vdx_neg[AVDX_W-1:0] : vdxs_reg[AVDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg     <= d1_full[D_W-1:0];
            d2_reg     <= d2_full[D_W-1:0];
            w_reg      <= w_next;
            avdx_reg   <= avdx_next;
            dx2_s3_reg <= dx2_reg;
            bad1_reg   <= s1_reg >= ONE_S;
            bad2_reg   <= s2_reg >= ONE_S;
        end
    end

    // Wide products: d1*d2 for gamma and (v1 dot dx)^2 for the proper distance.
    logic [PROD_W-1:0] gam_prod, vsq;

    rlpk_mul_wide #(.IN_W(MUL_W)) u_mul_gam (
        .clk  (clk),
        .en   (adv),
        .a    (MUL_W'(d1_reg)),
        .b    (MUL_W'(d2_reg)),
        .prod (gam_prod)
    );

    rlpk_mul_wide #(.IN_W(MUL_W)) u_mul_vdx (
        .clk  (clk),
        .en   (adv),
        .a    (MUL_W'(avdx_reg)),
        .b    (MUL_W'(avdx_reg)),
        .prod (vsq)
    );

    // Gamma path: square root of d1*d2 scaled, then w scaled over that root.
    rlpk_pkg::gam_side_t gam_side_in, gam_side_out;
    logic [GRW-1:0]      gam_root;

    assign gam_side_in = '{w: w_reg, bad: bad1_reg | bad2_reg};

    rlpk_delay #(.WIDTH($bits(rlpk_pkg::gam_side_t)), .DEPTH(rlpk_pkg::GAM_SIDE_DLY)) u_gam_side (
        .clk  (clk),
        .en   (adv),
        .din  (gam_side_in),
        .dout (gam_side_out)
    );

    rlpk_sqrt #(.ROOT_W(GRW)) u_sqrt_gam (
        .clk  (clk),
        .en   (adv),
        .rad  ({gam_prod[2*GRW-SHIFT-1:0], {SHIFT{1'b0}}}),
        .root (gam_root)
    );

    // Gamma divider setup; the quotient saturates once w reaches four times the root.
    logic [GRW+1:0]      gam_w_ext;
    logic [GRW-1:0]      gp_rem_reg, gp_den_reg;
    logic [GQW-1:0]      gp_low_reg, gam_quo;
    rlpk_pkg::gam_tail_t gp_tail_next, gp_tail_reg, gam_tail_out;

    assign gam_w_ext    = (GRW+2)'(gam_side_out.w);
    assign gp_tail_next = '{sat: gam_side_out.bad || gam_w_ext >= {gam_root, 2'b00},
                            bad: gam_side_out.bad};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gp_rem_reg  <= GRW'(gam_side_out.w >> 2);
            gp_low_reg  <= {gam_side_out.w[1:0], {(GQW-2){1'b0}}};
            gp_den_reg  <= gam_root;
            gp_tail_reg <= gp_tail_next;
        end
    end

    rlpk_div #(.DEN_W(GRW), .QUO_W(GQW)) u_div_gam (
        .clk      (clk),
        .en       (adv),
        .rem_init (gp_rem_reg),
        .num_low  (gp_low_reg),
        .den      (gp_den_reg),
        .quo      (gam_quo)
    );

    rlpk_delay #(.WIDTH($bits(rlpk_pkg::gam_tail_t)), .DEPTH(GQW)) u_gam_tail (
        .clk  (clk),
        .en   (adv),
        .din  (gp_tail_reg),
        .dout (gam_tail_out)
    );

    // Separation path: floor((v1 dot dx)^2 / d1) is added to the squared lab distance.
    rlpk_pkg::sep_side_t sep_side_in, sep_side_out;

    assign sep_side_in = '{d1: d1_reg, dx2: dx2_s3_reg, bad1: bad1_reg};

    rlpk_delay #(.WIDTH($bits(rlpk_pkg::sep_side_t)), .DEPTH(rlpk_pkg::MUL_LAT)) u_sep_side (
        .clk  (clk),
        .en   (adv),
        .din  (sep_side_in),
        .dout (sep_side_out)
    );

    logic [D_W-1:0]     sp_rem_next, sp_rem_reg, sp_den_reg;
    logic [SQW-1:0]     sp_low_reg, sep_quo;
    rlpk_pkg::sep_mid_t sp_mid_reg, sep_mid_out;

    assign sp_rem_next = D_W'(vsq[PROD_W-1:SQW]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_rem_reg <= sp_rem_next;
            sp_low_reg <= vsq[SQW-1:0];
            sp_den_reg <= sep_side_out.d1;
            sp_mid_reg <= '{dx2: sep_side_out.dx2, bad1: sep_side_out.bad1,
                            sat: sp_rem_next >= sep_side_out.d1};
        end
    end

    rlpk_div #(.DEN_W(D_W), .QUO_W(SQW)) u_div_sep (
        .clk      (clk),
        .en       (adv),
        .rem_init (sp_rem_reg),
        .num_low  (sp_low_reg),
        .den      (sp_den_reg),
        .quo      (sep_quo)
    );

    rlpk_delay #(.WIDTH($bits(rlpk_pkg::sep_mid_t)), .DEPTH(SQW)) u_sep_mid (
        .clk  (clk),
        .en   (adv),
        .din  (sp_mid_reg),
        .dout (sep_mid_out)
    );

    // Pick the squared distance by mode and flag the forced outcomes.
    logic [SQW:0]         sep_sum;
    logic [SQW-1:0]       sc_rad_next, sc_rad_reg;
    rlpk_pkg::sep_flags_t sc_flags_next, sc_flags_reg, sep_flags_out;
    logic [SRW-1:0]       sep_root, sep_root_out;

    assign sep_sum = (SQW+1)'(sep_quo) + (SQW+1)'(sep_mid_out.dx2);

    always_comb
    begin
        unique case (sep_mode_reg)
            rlpk_pkg::MODE_LAB:
            begin
                sc_rad_next   = SQW'(sep_mid_out.dx2);
                sc_flags_next = '{force_zero: 1'b0, force_max: 1'b0};
            end
            rlpk_pkg::MODE_PROPER:
            begin
                sc_rad_next   = sep_sum[SQW-1:0];
                sc_flags_next = '{force_zero: sep_mid_out.bad1,
                                  force_max:  !sep_mid_out.bad1
                                              && (sep_mid_out.sat || sep_sum[SQW])};
            end
            default:
            begin
                sc_rad_next   = SQW'(sep_mid_out.dx2);
                sc_flags_next = '{force_zero: 1'b0, force_max: 1'b0};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_rad_reg   <= sc_rad_next;
            sc_flags_reg <= sc_flags_next;
        end
    end

    rlpk_sqrt #(.ROOT_W(SRW)) u_sqrt_sep (
        .clk  (clk),
        .en   (adv),
        .rad  (sc_rad_reg),
        .root (sep_root)
    );

    rlpk_delay #(.WIDTH($bits(rlpk_pkg::sep_flags_t)), .DEPTH(SRW + rlpk_pkg::SEP_ALIGN))
        u_sep_flags (
        .clk  (clk),
        .en   (adv),
        .din  (sc_flags_reg),
        .dout (sep_flags_out)
    );

    rlpk_delay #(.WIDTH(SRW), .DEPTH(rlpk_pkg::SEP_ALIGN)) u_sep_root (
        .clk  (clk),
        .en   (adv),
        .din  (sep_root),
        .dout (sep_root_out)
    );

    // Final result assembly.
    rlpk_pkg::result_t res_next, out_data_reg, skid_data_reg;

    always_comb
    begin
        priority if (sep_flags_out.force_zero)
        begin
            res_next.separation = '0;
        end
        else if (sep_flags_out.force_max)
        begin
            res_next.separation = rlpk_pkg::SEP_MAX;
        end
        else
        begin
            res_next.separation = sep_root_out;
        end

        priority if (gam_tail_out.sat)
        begin
            res_next.relative_gamma = rlpk_pkg::GAM_MAX;
        end
        else if (gam_quo < rlpk_pkg::GAM_MIN)
        begin
            res_next.relative_gamma = rlpk_pkg::GAM_MIN;
        end
        else
        begin
            res_next.relative_gamma = gam_quo;
        end

        res_next.speed_invalid = gam_tail_out.bad;
    end

    // Output register with one skid entry behind it.
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || pipe_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end
        else if (pipe_fire)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign separation     = out_data_reg.separation;
    assign relative_gamma = out_data_reg.relative_gamma;
    assign speed_invalid  = out_data_reg.speed_invalid;

`ifndef SYNTHESIS
    // The skid entry only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register is empty");

    // A stalled output beat is never dropped.
    a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled output beat lost");

    // Relative gamma never falls below one.
    a_gamma_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.relative_gamma >= rlpk_pkg::GAM_MIN)
        else $error("relative gamma below one");

    // An invalid speed forces the saturated gamma.
    a_bad_speed_gamma: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.speed_invalid
            |-> out_data_reg.relative_gamma == rlpk_pkg::GAM_MAX)
        else $error("invalid speed without saturated gamma");
`endif

endmodule

### tb/sv/rlpk_checker.sv
// Checker for the pair kernel: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module rlpk_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [17:0] first_vel_x,
    input  logic [17:0] first_vel_y,
    input  logic [17:0] first_vel_z,
    input  logic [15:0] first_pos_x,
    input  logic [15:0] first_pos_y,
    input  logic [15:0] first_pos_z,
    input  logic [17:0] second_vel_x,
    input  logic [17:0] second_vel_y,
    input  logic [17:0] second_vel_z,
    input  logic [15:0] second_pos_x,
    input  logic [15:0] second_pos_y,
    input  logic [15:0] second_pos_z,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [23:0] separation,
    input  logic [31:0] relative_gamma,
    input  logic        speed_invalid,
    output int          fail_count,
    output int          results_pending,
    output int          results_checked,
    output int          invalid_seen,
    output int          proper_seen
);

    localparam logic [127:0] ONE_Q34 = 128'd1 << (2 * rlpk_pkg::VEL_FRAC_BITS);

    // Model copy of the mode register and the results still owed by the block.
    logic               sep_mode;
    rlpk_pkg::result_t  owed_results[$];

    // Floor square root of a wide value.
    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= x) r = c[63:0];
        end
        return r;
    endfunction

    // Distance from a squared separation N/D in Q32 with saturation.
    function automatic logic [rlpk_pkg::SEP_W-1:0] sep_from(input logic [127:0] n,
                                                            input logic [127:0] d);
        logic [127:0] q;
        logic [63:0]  r;
        if (n >= (d << 48)) return rlpk_pkg::SEP_MAX;
        q = n / d;
        r = floor_root(q);
        return (r > 64'(rlpk_pkg::SEP_MAX)) ? rlpk_pkg::SEP_MAX : r[rlpk_pkg::SEP_W-1:0];
    endfunction

    // Expected result of one pair under the given separation mode.
    function automatic rlpk_pkg::result_t predict_pair(input logic mode,
                                                       input logic signed [17:0] va[3],
                                                       input logic signed [17:0] vb[3],
                                                       input logic [15:0] pa[3],
                                                       input logic [15:0] pb[3]);
        rlpk_pkg::result_t res;
        longint            a, b, dx, dot, vdx;
        logic [127:0]      s1, s2, dx2, d1, d2, av, w, rt, num;
        logic              bad1, bad2;
        s1 = '0; s2 = '0; dx2 = '0; dot = 0; vdx = 0;
        for (int i = 0; i < 3; i++)
        begin
            a   = longint'(va[i]);
            b   = longint'(vb[i]);
            dx  = longint'(pb[i]) - longint'(pa[i]);
            s1  += 128'(a * a);
            s2  += 128'(b * b);
            dx2 += 128'(dx * dx);
            dot += a * b;
            vdx += a * dx;
        end
        bad1 = s1 >= ONE_Q34;
        bad2 = s2 >= ONE_Q34;

        if (mode == rlpk_pkg::MODE_LAB)
        begin
            res.separation = sep_from(dx2, 128'd1);
        end
        else if (bad1)
        begin
            res.separation = '0;
        end
        else
        begin
            d1 = ONE_Q34 - s1;
            av = 128'(vdx < 0 ? -vdx : vdx);
            res.separation = sep_from(dx2 * d1 + av * av, d1);
        end

        if (bad1 || bad2)
        begin
            res.relative_gamma = rlpk_pkg::GAM_MAX;
        end
        else
        begin
            d1 = ONE_Q34 - s1;
            d2 = ONE_Q34 - s2;
            w = (longint'(ONE_Q34) - dot < 1) ? 128'd1 : 128'(longint'(ONE_Q34) - dot);
            rt = {64'd0, floor_root((d1 * d2) << rlpk_pkg::GAM_SHIFT)};
            num = w << 30;
            if (num >= (rt << 32)) res.relative_gamma = rlpk_pkg::GAM_MAX;
            else
            begin
                res.relative_gamma = rlpk_pkg::GAM_W'(num / rt);
                if (res.relative_gamma < rlpk_pkg::GAM_MIN)
                    res.relative_gamma = rlpk_pkg::GAM_MIN;
            end
        end
        res.speed_invalid = bad1 || bad2;
        return res;
    endfunction

    // Track the mode, predict accepted input beats and check accepted output beats.
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [17:0] va[3], vb[3];
        logic [15:0]        pa[3], pb[3];
        rlpk_pkg::result_t  want;
        if (!rst_n)
        begin
            sep_mode <= rlpk_pkg::MODE_LAB;
            owed_results.delete();
            fail_count <= 0;
            results_pending <= 0;
            results_checked <= 0;
            invalid_seen <= 0;
            proper_seen <= 0;
        end
        else
        begin
            if (cfg_wr_en) sep_mode <= cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                va = '{first_vel_x, first_vel_y, first_vel_z};
                vb = '{second_vel_x, second_vel_y, second_vel_z};
                pa = '{first_pos_x, first_pos_y, first_pos_z};
                pb = '{second_pos_x, second_pos_y, second_pos_z};
                want = predict_pair(sep_mode, va, vb, pa, pb);
                owed_results.push_back(want);
                if (sep_mode == rlpk_pkg::MODE_PROPER) proper_seen <= proper_seen + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %s sep=%0d gamma=%0d inv=%0b",
                             $time, "actual", separation, relative_gamma, speed_invalid);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = owed_results.pop_front();
                    results_checked <= results_checked + 1;
                    if (want.speed_invalid) invalid_seen <= invalid_seen + 1;
                    if (want.separation !== separation
                        || want.relative_gamma !== relative_gamma
                        || want.speed_invalid !== speed_invalid)
                    begin
                        $display("%0t: mismatch: expected sep=%0d gamma=%0d inv=%0b,",
                                 $time, want.separation, want.relative_gamma,
                                 want.speed_invalid);
                        $display("%0t:           actual   sep=%0d gamma=%0d inv=%0b",
                                 $time, separation, relative_gamma, speed_invalid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            results_pending <= owed_results.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// Top of the pair kernel testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_PAIRS = 1650;

    typedef struct {
        logic [17:0] va[3];
        logic [15:0] pa[3];
        logic [17:0] vb[3];
        logic [15:0] pb[3];
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [17:0] first_vel_x, first_vel_y, first_vel_z;
    logic [15:0] first_pos_x, first_pos_y, first_pos_z;
    logic [17:0] second_vel_x, second_vel_y, second_vel_z;
    logic [15:0] second_pos_x, second_pos_y, second_pos_z;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] separation;
    logic [31:0] relative_gamma;
    logic        speed_invalid;

    int  fail_count, results_pending, results_checked, invalid_seen, proper_seen;
    int  idle_cycles;
    int  burst_left;
    bit  hold_request;

    relative_lorentz_pair_kernel_unit DUT (.*);

    rlpk_checker checker_i (.*);

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("relative_lorentz_pair_kernel_unit test failed");
            $finish;
        end
    end

    // Receiver: a random stall after each result beat, quiet runs and one long hold-off.
    initial
    begin
        int stall_left;
        int quiet_left;
        stall_left = 0;
        quiet_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = 600;
            end
            else if (out_valid && !out_stall)
            begin
                if (quiet_left > 0) quiet_left--;
                else if ($urandom_range(0, 29) == 0) quiet_left = 60;
                stall_left = (quiet_left > 0) ? 0 : $urandom_range(0, 19);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // One velocity component: small, full range, near light speed or the most negative code.
    function automatic logic [17:0] draw_vel(input int kind);
        case (kind)
            0: return 18'($signed($urandom_range(0, 148000)) - 74000);
            1: return 18'($urandom);
            2: return $urandom_range(0, 1) ? 18'(131071 - $urandom_range(0, 200))
                                           : 18'(-131071 + $urandom_range(0, 200));
            default: return 18'h20000;
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    k1, k2;
        k1 = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 3);
        k2 = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < 3; i++)
        begin
            p.va[i] = draw_vel((i == 0 || k1 == 1) ? k1 : 0);
            p.vb[i] = draw_vel((i == 1 || k2 == 1) ? k2 : 0);
            p.pa[i] = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom);
            p.pb[i] = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
        end
        if ($urandom_range(0, 19) == 0) p.va = '{18'd0, 18'd0, 18'd0};
        return p;
    endfunction

    function automatic pair_t make_pair(input logic [17:0] a, input logic [17:0] b,
                                        input logic [15:0] p1, input logic [15:0] p2);
        pair_t p;
        p.va = '{a, 18'd0, 18'd0};
        p.vb = '{b, 18'd0, 18'd0};
        p.pa = '{p1, p1, 16'd0};
        p.pb = '{p2, p2, 16'hFFFF};
        return p;
    endfunction

    // Offer one beat after a random gap and wait until it is taken.
    task automatic send_pair(input pair_t p, input bit no_gap);
        int gap;
        if (burst_left > 0) burst_left--;
        else if ($urandom_range(0, 39) == 0) burst_left = 80;
        gap = (no_gap || burst_left > 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        {first_vel_x, first_vel_y, first_vel_z} <= {p.va[0], p.va[1], p.va[2]};
        {first_pos_x, first_pos_y, first_pos_z} <= {p.pa[0], p.pa[1], p.pa[2]};
        {second_vel_x, second_vel_y, second_vel_z} <= {p.vb[0], p.vb[1], p.vb[2]};
        {second_pos_x, second_pos_y, second_pos_z} <= {p.pb[0], p.pb[1], p.pb[2]};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain the pipe, then write the mode register.
    task automatic set_mode(input logic mode);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (rlpk_pkg::PIPE_DEPTH + 10) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_pairs();
        pair_t p;
        send_pair(make_pair(18'd0, 18'd0, 16'd0, 16'd0), 1'b0);
        send_pair(make_pair(18'd0, 18'd131071, 16'd0, 16'hFFFF), 1'b0);
        send_pair(make_pair(18'd131071, 18'd0, 16'hFFFF, 16'd0), 1'b0);
        send_pair(make_pair(18'h20000, 18'd0, 16'd100, 16'd200), 1'b0);
        send_pair(make_pair(18'd0, 18'h20000, 16'd100, 16'd200), 1'b0);
        send_pair(make_pair(18'd131071, 18'(-131071), 16'd0, 16'hFFFF), 1'b0);
        send_pair(make_pair(18'd120000, 18'd120000, 16'd5, 16'd9), 1'b0);
        send_pair(make_pair(18'd130000, 18'(-130000), 16'd1, 16'hFFFE), 1'b0);
        send_pair(make_pair(18'(-65536), 18'd65536, 16'hFFFF, 16'hFFFF), 1'b0);
        p = make_pair(18'd131071, 18'd0, 16'd0, 16'hFFFF);
        p.va = '{18'd80000, 18'd80000, 18'd80000};
        send_pair(p, 1'b0);
        p.va = '{18'd75000, 18'd75000, 18'(-75000)};
        p.vb = '{18'(-75000), 18'(-75000), 18'd75000};
        send_pair(p, 1'b0);
        for (int i = 0; i < 8; i++) send_pair(random_pair(), 1'b0);
    endtask

    // Stimulus: directed pairs in both modes, then random phases that alternate the mode.
    initial
    begin
        logic mode;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        {first_vel_x, first_vel_y, first_vel_z} <= '0;
        {first_pos_x, first_pos_y, first_pos_z} <= '0;
        {second_vel_x, second_vel_y, second_vel_z} <= '0;
        {second_pos_x, second_pos_y, second_pos_z} <= '0;
        hold_request = 1'b0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(rlpk_pkg::MODE_LAB);
        directed_pairs();
        set_mode(rlpk_pkg::MODE_PROPER);
        directed_pairs();

        mode = rlpk_pkg::MODE_PROPER;
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 1)
            begin
                // Fill the pipe against a long receiver hold-off.
                hold_request = 1'b1;
                for (int i = 0; i < 200; i++) send_pair(random_pair(), 1'b1);
            end
            for (int i = 0; i < RANDOM_PAIRS / 4 - (ph == 1 ? 200 : 0); i++)
                send_pair(random_pair(), 1'b0);
            mode = (mode == rlpk_pkg::MODE_PROPER) ? rlpk_pkg::MODE_LAB
                                                   : rlpk_pkg::MODE_PROPER;
            set_mode(mode);
        end

        in_valid <= 1'b0;
        while (results_pending != 0) @(posedge clk);
        repeat (rlpk_pkg::PIPE_DEPTH + 10) @(posedge clk);
        $display("Checked %0d result beats: %0d in proper-distance mode,",
                 results_checked, proper_seen);
        $display("%0d of them with a flagged speed.", invalid_seen);
        if (fail_count == 0 && results_pending == 0)
            $display("relative_lorentz_pair_kernel_unit test passed");
        else
            $display("relative_lorentz_pair_kernel_unit test failed");
        $finish;
    end

endmodule
